// ----- rtl/dpd_pkg.sv -----
// Shared types, widths and register codes for the depth pixel deprojection core.
package dpd_pkg;

  // Fixed field and datapath widths
  localparam int NORM_W  = 42;  // normalised coordinate, Q.24, unclamped
  localparam int U_W     = 44;  // corrected coordinate, Q.24
  localparam int CL_W    = 27;  // clamped coordinate, Q.24 within [-2, +2]
  localparam int TS_W    = 33;  // sum of the two rounded tangential terms
  localparam int POINT_W = 19;  // point_x and point_y
  localparam int Z_W     = 16;  // point_z

  // Register port
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int INDEX_W = ADDR_W - 3;

  localparam logic [INDEX_W-1:0] REG_PRINCIPAL  = 3'd0;
  localparam logic [INDEX_W-1:0] REG_INV_FX     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_INV_FY     = 3'd2;
  localparam logic [INDEX_W-1:0] REG_RADIAL     = 3'd3;
  localparam logic [INDEX_W-1:0] REG_TANGENTIAL = 3'd4;
  localparam logic [INDEX_W-1:0] REG_MODE       = 3'd5;

  localparam logic [POINT_W-1:0] POINT_LIMIT = 19'd262143;

  typedef struct packed {
    logic [31:0] principal_point;
    logic [31:0] inverse_focal_x;
    logic [31:0] inverse_focal_y;
    logic [47:0] radial_coeffs;
    logic [31:0] tangential_coeffs;
    logic        distortion_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
  } norm_t;

  typedef struct packed {
    logic signed [U_W-1:0] x;
    logic signed [U_W-1:0] y;
  } upoint_t;

endpackage

// ----- rtl/depth_pixel_deprojection_core.sv -----
// Top level of the depth pixel deprojection core: registers and datapath pipeline.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   pixel    | pixel_valid / pixel_stall | pixel_x, pixel_y, depth_mm
//   point    | point_valid / point_stall | point_x, point_y, point_z
//   config   | psel, penable, pready     | pwrite, paddr, pwdata, prdata
//
// One pixel per clock unless stalled; 3 normalise, 12 correction and 3 scaling stages.
// The correction stages run in both modes; plain pinhole mode selects the bypassed point.
// Synchronous reset empties the pipeline and clears every configuration register to zero.
// A stall freezes the stage chain only while the output request is held; bubbles close up
// at each module boundary.
module depth_pixel_deprojection_core #(
  parameter int PIXEL_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  logic [PIXEL_BITS-1:0]              pixel_x,
  input  logic [PIXEL_BITS-1:0]              pixel_y,
  input  logic [DEPTH_BITS-1:0]              depth_mm,
  output logic                               point_valid,
  input  logic                               point_stall,
  output logic signed [dpd_pkg::POINT_W-1:0] point_x,
  output logic signed [dpd_pkg::POINT_W-1:0] point_y,
  output logic [dpd_pkg::Z_W-1:0]            point_z,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dpd_pkg::ADDR_W-1:0]         paddr,
  input  logic [dpd_pkg::DATA_W-1:0]         pwdata,
  output logic [dpd_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import dpd_pkg::*;

  cfg_t                  cfg;
  norm_t                 norm;
  upoint_t               upt;
  logic [DEPTH_BITS-1:0] dep_n, dep_d;
  logic                  n_valid, n_stall, d_valid, d_stall;

  dpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpd_normalise #(
    .PIXEL_BITS (PIXEL_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_stall  (pixel_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .depth_mm  (depth_mm),
    .cfg       (cfg),
    .out_valid (n_valid),
    .out_stall (n_stall),
    .norm      (norm),
    .depth     (dep_n)
  );

  dpd_distort #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (n_valid),
    .in_stall  (n_stall),
    .norm      (norm),
    .depth_in  (dep_n),
    .cfg       (cfg),
    .out_valid (d_valid),
    .out_stall (d_stall),
    .upt       (upt),
    .depth_out (dep_d)
  );

  dpd_scale #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_stall  (d_stall),
    .upt       (upt),
    .depth_in  (dep_d),
    .out_valid (point_valid),
    .out_stall (point_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z)
  );

  // Input back-pressure only arises from a held output request
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (point_valid && point_stall))
    else $error("pixel_stall raised without a held output request");

  // A zero depth gives the origin
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (point_valid && (point_z == '0) && (DEPTH_BITS <= Z_W)) |->
    ((point_x == '0) && (point_y == '0)))
    else $error("non-zero point for zero depth");

  // Saturation is symmetric, so the most negative code never appears
  a_sat_symmetric: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> ((point_x != -19'sd262144) && (point_y != -19'sd262144)))
    else $error("point outside the symmetric saturation range");

  // The pipeline is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !point_valid)
    else $error("output request present after reset");

endmodule

// ----- rtl/dpd_cfg_regs.sv -----
// Configuration register file behind the APB-style port.
module dpd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpd_pkg::ADDR_W-1:0] paddr,
  input  logic [dpd_pkg::DATA_W-1:0] pwdata,
  output logic [dpd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dpd_pkg::cfg_t              cfg
);
  import dpd_pkg::*;

  logic               wr;
  logic [INDEX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:3];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_PRINCIPAL:  cfg.principal_point   <= pwdata[31:0];
        REG_INV_FX:     cfg.inverse_focal_x   <= pwdata[31:0];
        REG_INV_FY:     cfg.inverse_focal_y   <= pwdata[31:0];
        REG_RADIAL:     cfg.radial_coeffs     <= pwdata[47:0];
        REG_TANGENTIAL: cfg.tangential_coeffs <= pwdata[31:0];
        REG_MODE:       cfg.distortion_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (idx)
      REG_PRINCIPAL:  prdata = {32'd0, cfg.principal_point};
      REG_INV_FX:     prdata = {32'd0, cfg.inverse_focal_x};
      REG_INV_FY:     prdata = {32'd0, cfg.inverse_focal_y};
      REG_RADIAL:     prdata = {16'd0, cfg.radial_coeffs};
      REG_TANGENTIAL: prdata = {32'd0, cfg.tangential_coeffs};
      REG_MODE:       prdata = {63'd0, cfg.distortion_mode};
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/dpd_normalise.sv -----
// Pixel normalisation: subtract the principal point and scale by the inverse focal length.
module dpd_normalise #(
  parameter int PIXEL_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] pixel_x,
  input  logic [PIXEL_BITS-1:0] pixel_y,
  input  logic [DEPTH_BITS-1:0] depth_mm,
  input  dpd_pkg::cfg_t         cfg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dpd_pkg::norm_t        norm,
  output logic [DEPTH_BITS-1:0] depth
);
  import dpd_pkg::*;

  localparam int SHIFT_W = PIXEL_BITS + 4;
  localparam int SUB_W   = ((SHIFT_W > 16) ? SHIFT_W : 16) + 1;
  localparam int PROD_W  = SUB_W + 33;
  localparam int STAGES  = 3;
  localparam logic signed [PROD_W-1:0] HALF12 = PROD_W'(2048);

  logic [STAGES-1:0]        vld;
  logic                     en;
  logic signed [SUB_W-1:0]  dx, dy;
  logic signed [PROD_W-1:0] px_prod, py_prod;
  logic signed [PROD_W-1:0] sx, sy;
  logic [DEPTH_BITS-1:0]    dep0, dep1;

  // Advance the whole stage chain unless the last request is held
  assign en        = !(vld[STAGES-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[STAGES-1];

  assign sx = px_prod + HALF12;
  assign sy = py_prod + HALF12;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Offset from the principal point in Q.4
      dx   <= $signed(SUB_W'({pixel_x, 4'b0000})) - $signed(SUB_W'(cfg.principal_point[15:0]));
      dy   <= $signed(SUB_W'({pixel_y, 4'b0000})) - $signed(SUB_W'(cfg.principal_point[31:16]));
      dep0 <= depth_mm;
      // Scale by the reciprocal focal length
      px_prod <= dx * $signed({1'b0, cfg.inverse_focal_x});
      py_prod <= dy * $signed({1'b0, cfg.inverse_focal_y});
      dep1    <= dep0;
      // Round half up into Q.24
      norm.x <= NORM_W'($signed(sx[PROD_W-1:12]));
      norm.y <= NORM_W'($signed(sy[PROD_W-1:12]));
      depth  <= dep1;
    end
  end

endmodule

// ----- rtl/dpd_distort.sv -----
// Inverse Brown-Conrady correction pipeline, bypassed in plain pinhole mode.
module dpd_distort #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dpd_pkg::norm_t        norm,
  input  logic [DEPTH_BITS-1:0] depth_in,
  input  dpd_pkg::cfg_t         cfg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dpd_pkg::upoint_t      upt,
  output logic [DEPTH_BITS-1:0] depth_out
);
  import dpd_pkg::*;

  localparam int STAGES = 12;
  localparam logic signed [NORM_W-1:0] CLAMP_HI = NORM_W'(33554432);
  localparam logic signed [NORM_W-1:0] CLAMP_LO = -CLAMP_HI;
  localparam logic signed [53:0] H23_54 = 54'sd8388608;
  localparam logic signed [57:0] H23_58 = 58'sd8388608;
  localparam logic signed [60:0] H23_61 = 61'sd8388608;
  localparam logic signed [66:0] H23_67 = 67'sd8388608;
  localparam logic signed [45:0] H13_46 = 46'sd8192;
  localparam logic signed [52:0] F_BIAS = (53'sd1 <<< 38) + (53'sd1 <<< 13);

  typedef struct packed {
    logic signed [CL_W-1:0] x;
    logic signed [CL_W-1:0] y;
  } clpair_t;

  logic [STAGES-1:0] vld;
  logic              en;

  // Carried alongside the arithmetic
  norm_t                 raw_q [0:10];
  logic [DEPTH_BITS-1:0] dep_q [0:11];
  clpair_t               cl_q  [0:8];
  logic signed [TS_W-1:0] tsx_q [4:10];
  logic signed [TS_W-1:0] tsy_q [4:10];

  // Stage registers
  logic signed [53:0] pxx, pyy, pxy;
  logic signed [27:0] xx, yy, xy;
  logic signed [28:0] r2_2, r2_3, r2_4;
  logic signed [57:0] pr4;
  logic signed [45:0] tx1, tx2, ty1, ty2;
  logic signed [31:0] r4;
  logic signed [60:0] pr6;
  logic signed [44:0] pk1;
  logic signed [47:0] pk2;
  logic signed [34:0] r6;
  logic signed [48:0] s12_6, s12_7;
  logic signed [50:0] pk3;
  logic signed [38:0] f;
  logic signed [46:0] pxl, pxh, pyl, pyh;
  logic signed [41:0] xf, yf;

  // Combinational terms
  clpair_t            cl_w;
  logic signed [53:0] sxx, syy, sxy;
  logic signed [27:0] xx_w, yy_w, xy_w;
  logic signed [28:0] r2_w;
  logic signed [29:0] a2x, a2y;
  logic signed [28:0] xy2;
  logic signed [57:0] s4;
  logic signed [45:0] rtx1, rtx2, rty1, rty2;
  logic signed [TS_W-1:0] tsx_w, tsy_w;
  logic signed [60:0] s6;
  logic signed [52:0] fs;
  logic signed [19:0] fl_s, fh_s;
  logic signed [66:0] xs, ys;
  logic signed [15:0] k1, k2, k3, p1, p2;

  assign en        = !(vld[STAGES-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[STAGES-1];
  assign depth_out = dep_q[11];

  assign k1 = $signed(cfg.radial_coeffs[15:0]);
  assign k2 = $signed(cfg.radial_coeffs[31:16]);
  assign k3 = $signed(cfg.radial_coeffs[47:32]);
  assign p1 = $signed(cfg.tangential_coeffs[15:0]);
  assign p2 = $signed(cfg.tangential_coeffs[31:16]);

  // Clamp to [-2, +2] before the correction
  always_comb begin
    cl_w.x = CL_W'((norm.x > CLAMP_HI) ? CLAMP_HI : ((norm.x < CLAMP_LO) ? CLAMP_LO : norm.x));
    cl_w.y = CL_W'((norm.y > CLAMP_HI) ? CLAMP_HI : ((norm.y < CLAMP_LO) ? CLAMP_LO : norm.y));
  end

  // Round the squares and cross term, form r^2
  assign sxx  = pxx + H23_54;
  assign syy  = pyy + H23_54;
  assign sxy  = pxy + H23_54;
  assign xx_w = sxx[51:24];
  assign yy_w = syy[51:24];
  assign xy_w = sxy[51:24];
  assign r2_w = 29'(xx_w) + 29'(yy_w);

  // Operands of the tangential terms
  assign a2x = 30'(r2_2) + (30'(xx) <<< 1);
  assign a2y = 30'(r2_2) + (30'(yy) <<< 1);
  assign xy2 = 29'(xy) <<< 1;

  // Round r^4 and both tangential sums
  assign s4    = pr4 + H23_58;
  assign rtx1  = tx1 + H13_46;
  assign rtx2  = tx2 + H13_46;
  assign rty1  = ty1 + H13_46;
  assign rty2  = ty2 + H13_46;
  assign tsx_w = TS_W'($signed(rtx1[45:14])) + TS_W'($signed(rtx2[45:14]));
  assign tsy_w = TS_W'($signed(rty1[45:14])) + TS_W'($signed(rty2[45:14]));

  assign s6 = pr6 + H23_61;

  // Radial factor f = 1 + rnd(k1 r2 + k2 r4 + k3 r6, 14), folded into one sum
  assign fs = 53'(s12_7) + 53'(pk3) + F_BIAS;

  // Split f so that each product stays narrow
  assign fl_s = $signed({1'b0, f[18:0]});
  assign fh_s = f[38:19];

  assign xs = (67'(pxh) <<< 19) + 67'(pxl) + H23_67;
  assign ys = (67'(pyh) <<< 19) + 67'(pyl) + H23_67;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Shift lines for the raw point, depth, clamped point and tangential sums
      raw_q[0] <= norm;
      for (int i = 1; i <= 10; i++) raw_q[i] <= raw_q[i-1];
      dep_q[0] <= depth_in;
      for (int i = 1; i <= 11; i++) dep_q[i] <= dep_q[i-1];
      cl_q[0] <= cl_w;
      for (int i = 1; i <= 8; i++) cl_q[i] <= cl_q[i-1];
      tsx_q[4] <= tsx_w;
      tsy_q[4] <= tsy_w;
      for (int i = 5; i <= 10; i++) begin
        tsx_q[i] <= tsx_q[i-1];
        tsy_q[i] <= tsy_q[i-1];
      end

      // Squares and cross term
      pxx <= cl_q[0].x * cl_q[0].x;
      pyy <= cl_q[0].y * cl_q[0].y;
      pxy <= cl_q[0].x * cl_q[0].y;

      xx   <= xx_w;
      yy   <= yy_w;
      xy   <= xy_w;
      r2_2 <= r2_w;

      // r^4 product and the four tangential products
      pr4  <= r2_2 * r2_2;
      tx1  <= p1 * xy2;
      tx2  <= p2 * a2x;
      ty1  <= p2 * xy2;
      ty2  <= p1 * a2y;
      r2_3 <= r2_2;

      r4   <= s4[55:24];
      r2_4 <= r2_3;

      // r^6 product and the first two radial terms
      pr6 <= r4 * r2_4;
      pk1 <= k1 * r2_4;
      pk2 <= k2 * r4;

      r6    <= s6[58:24];
      s12_6 <= 49'(pk1) + 49'(pk2);

      pk3   <= k3 * r6;
      s12_7 <= s12_6;

      f <= fs[52:14];

      pxl <= cl_q[8].x * fl_s;
      pxh <= cl_q[8].x * fh_s;
      pyl <= cl_q[8].y * fl_s;
      pyh <= cl_q[8].y * fh_s;

      xf <= xs[65:24];
      yf <= ys[65:24];

      // Pick the corrected or the plain point
      if (cfg.distortion_mode) begin
        upt.x <= U_W'(xf) + U_W'(tsx_q[10]);
        upt.y <= U_W'(yf) + U_W'(tsy_q[10]);
      end else begin
        upt.x <= U_W'(raw_q[10].x);
        upt.y <= U_W'(raw_q[10].y);
      end
    end
  end

endmodule

// ----- rtl/dpd_scale.sv -----
// Depth scaling, rounding and saturation of the camera-space point.
module dpd_scale #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dpd_pkg::upoint_t                   upt,
  input  logic [DEPTH_BITS-1:0]              depth_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dpd_pkg::POINT_W-1:0] point_x,
  output logic signed [dpd_pkg::POINT_W-1:0] point_y,
  output logic [dpd_pkg::Z_W-1:0]            point_z
);
  import dpd_pkg::*;

  localparam int STAGES = 3;
  localparam int MAG_W  = U_W - 1;
  localparam int LO_W   = 22;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int SUM_W  = DEPTH_BITS + MAG_W + 1;
  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(1) << (MAG_W - 1);
  localparam logic [SUM_W-1:0] HALF24    = SUM_W'(1) << 23;

  logic [STAGES-1:0]            vld;
  logic                         en;
  logic [U_W-1:0]               magx, magy;
  logic [MAG_W-1:0]             mx, my;
  logic                         negx0, negy0, negx1, negy1;
  logic [DEPTH_BITS-1:0]        dep0, dep1;
  logic [DEPTH_BITS+LO_W-1:0]   plx, ply;
  logic [DEPTH_BITS+HI_W-1:0]   phx, phy;
  logic [SUM_W-1:0]             sx, sy;
  logic [SUM_W-25:0]            qx, qy;
  logic [POINT_W-1:0]           qsx, qsy;

  assign en        = !(vld[STAGES-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[STAGES-1];

  // Magnitudes; anything beyond the limit saturates for every non-zero depth
  assign magx = upt.x[U_W-1] ? U_W'(-upt.x) : U_W'(upt.x);
  assign magy = upt.y[U_W-1] ? U_W'(-upt.y) : U_W'(upt.y);

  // Recombine the partial products and round half away from zero
  assign sx  = SUM_W'(plx) + (SUM_W'(phx) << LO_W) + HALF24;
  assign sy  = SUM_W'(ply) + (SUM_W'(phy) << LO_W) + HALF24;
  assign qx  = sx[SUM_W-1:24];
  assign qy  = sy[SUM_W-1:24];
  assign qsx = (qx > POINT_LIMIT) ? POINT_LIMIT : qx[POINT_W-1:0];
  assign qsy = (qy > POINT_LIMIT) ? POINT_LIMIT : qy[POINT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx    <= (magx > U_W'(MAG_LIMIT)) ? MAG_LIMIT : magx[MAG_W-1:0];
      my    <= (magy > U_W'(MAG_LIMIT)) ? MAG_LIMIT : magy[MAG_W-1:0];
      negx0 <= upt.x[U_W-1];
      negy0 <= upt.y[U_W-1];
      dep0  <= depth_in;

      // Depth times magnitude as two narrow partial products
      plx   <= dep0 * mx[LO_W-1:0];
      phx   <= dep0 * mx[MAG_W-1:LO_W];
      ply   <= dep0 * my[LO_W-1:0];
      phy   <= dep0 * my[MAG_W-1:LO_W];
      negx1 <= negx0;
      negy1 <= negy0;
      dep1  <= dep0;

      // Output register: restore the sign
      point_x <= negx1 ? POINT_W'(-qsx) : qsx;
      point_y <= negy1 ? POINT_W'(-qsy) : qsy;
      point_z <= Z_W'(dep1);
    end
  end

endmodule
